// ===== sv/tadic_pkg.sv =====
`default_nettype none

package tadic_pkg;

   // dividend bits walked by the remainder loop and cap on the defined-bit count
   localparam int unsigned REM_BITS = 64;

   // action codes
   localparam logic [2:0] ACT_CONVERT = 3'd0;
   localparam logic [2:0] ACT_ADD     = 3'd1;
   localparam logic [2:0] ACT_SUB     = 3'd2;
   localparam logic [2:0] ACT_MUL     = 3'd3;
   localparam logic [2:0] ACT_DIV     = 3'd4;
   localparam logic [2:0] ACT_POWER   = 3'd5;

   // configuration register indexes
   localparam logic [0:0] CSR_PRIME  = 1'd0;
   localparam logic [0:0] CSR_OFFSET = 1'd1;

   // finished result word handed from the sequencer to the output stage
   typedef struct packed {
      logic        valid;
      logic [63:0] value;
      logic [15:0] scale;
      logic [6:0]  known;
   } rsp_word_type;

endpackage

`default_nettype wire

// ===== sv/tadic_mul.sv =====
`default_nettype none

// shared 32x32 multiplier, product registered
module tadic_mul (
   input  wire logic        clock,
   input  wire logic [31:0] mul_a,
   input  wire logic [31:0] mul_b,
   output logic      [63:0] prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
   end

endmodule

`default_nettype wire

// ===== sv/tadic_seq.sv =====
`default_nettype none

module tadic_seq (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    go,
   input  wire logic [2:0]              action,
   input  wire logic [63:0]             a_value,
   input  wire logic [15:0]             a_scale,
   input  wire logic [6:0]              a_known,
   input  wire logic [63:0]             b_value,
   input  wire logic [15:0]             b_scale,
   input  wire logic [6:0]              b_known,
   input  wire logic [31:0]             prime,
   input  wire logic [31:0]             offset,
   output logic                         busy,
   output tadic_pkg::rsp_word_type      done
);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_DISP    = 5'd1;
   localparam logic [4:0] S_NORM    = 5'd2;
   localparam logic [4:0] S_NSHIFT  = 5'd3;
   localparam logic [4:0] S_RED     = 5'd4;
   localparam logic [4:0] S_REDEND  = 5'd5;
   localparam logic [4:0] S_CVLOOP  = 5'd6;
   localparam logic [4:0] S_ALIGN0  = 5'd7;
   localparam logic [4:0] S_ALIGN1  = 5'd8;
   localparam logic [4:0] S_ASHIFT  = 5'd9;
   localparam logic [4:0] S_ADDSUB  = 5'd10;
   localparam logic [4:0] S_MUL0    = 5'd11;
   localparam logic [4:0] S_MUL1    = 5'd12;
   localparam logic [4:0] S_MUL2    = 5'd13;
   localparam logic [4:0] S_MUL3    = 5'd14;
   localparam logic [4:0] S_DIVX    = 5'd15;
   localparam logic [4:0] S_DIVEND  = 5'd16;
   localparam logic [4:0] S_PWLOOP  = 5'd17;
   localparam logic [4:0] S_PWT     = 5'd18;
   localparam logic [4:0] S_PWSQ    = 5'd19;
   localparam logic [4:0] S_PWB     = 5'd20;
   localparam logic [4:0] S_PMINIT  = 5'd21;
   localparam logic [4:0] S_PMLOOP  = 5'd22;
   localparam logic [4:0] S_PMRX    = 5'd23;
   localparam logic [4:0] S_PMRR    = 5'd24;
   localparam logic [4:0] S_PMSQ    = 5'd25;
   localparam logic [4:0] S_PMSX    = 5'd26;
   localparam logic [4:0] S_PMSR    = 5'd27;
   localparam logic [4:0] S_PMFIN   = 5'd28;
   localparam logic [4:0] S_DONE    = 5'd29;

   localparam logic [6:0]  FULL_KNOWN = 7'(tadic_pkg::REM_BITS);
   localparam logic [16:0] FULL_D     = 17'(tadic_pkg::REM_BITS);

   logic [4:0]  state_ff, state_in, ret_ff, ret_in;
   logic [2:0]  act_ff, act_in;
   logic [63:0] x_v_ff, x_v_in, y_v_ff, y_v_in, w_v_ff, w_v_in, n_ff, n_in;
   logic [15:0] x_e_ff, x_e_in, y_e_ff, y_e_in, w_e_ff, w_e_in, s_ff, s_in;
   logic [16:0] x_d_ff, x_d_in, y_d_ff, y_d_in, w_d_ff, w_d_in;
   logic [31:0] rem_ff, rem_in, pr_ff, pr_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in, sq_ff, sq_in, sel_ff, sel_in;

   logic        mod_mode;
   logic [63:0] xa_v;
   logic [15:0] xa_e;
   logic [16:0] xa_d;
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic [32:0] rem_sh;
   logic [16:0] ediff, shift_dist;
   logic [6:0]  dcap;
   logic [63:0] nmask;
   logic [63:0] dbl;
   logic [63:0] hlf;
   logic [31:0] pr_one;

   function automatic logic [16:0] min17(input logic [16:0] p, input logic [16:0] q);
      return (q < p) ? q : p;
   endfunction

   function automatic logic [62:0] w_v_in_sub(input logic [63:0] r, input logic [63:0] dv);
      logic [63:0] diff;
      diff = r - dv;
      return diff[63:1];
   endfunction

   tadic_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   assign mod_mode   = (prime != 32'd0);
   assign xa_v       = sq_ff ? y_v_ff : x_v_ff;
   assign xa_e       = sq_ff ? y_e_ff : x_e_ff;
   assign xa_d       = sq_ff ? y_d_ff : x_d_ff;
   assign rem_sh     = {rem_ff, w_v_ff[63]};
   assign ediff      = 17'($signed({x_e_ff[15], x_e_ff}) - $signed({y_e_ff[15], y_e_ff}));
   assign shift_dist = ediff[16] ? 17'(-ediff) : ediff;
   assign dcap       = (w_d_ff > FULL_D) ? FULL_KNOWN : w_d_ff[6:0];
   assign dbl        = {w_v_ff[62:0], 1'b0};
   assign hlf        = w_v_ff[0] ? (w_v_ff + 64'(prime)) : w_v_ff;
   assign pr_one     = (prime == 32'd1) ? 32'd0 : 32'd1;

   always_comb begin
      for (int i = 0; i < 64; i++) begin
         nmask[i] = (7'(i) < dcap);
      end
   end

   // multiplier operand select
   always_comb begin
      unique case (state_ff)
         S_MUL0: begin
            mul_a = xa_v[31:0];
            mul_b = y_v_ff[31:0];
         end
         S_MUL1: begin
            mul_a = xa_v[31:0];
            mul_b = y_v_ff[63:32];
         end
         S_MUL2: begin
            mul_a = xa_v[63:32];
            mul_b = y_v_ff[31:0];
         end
         S_PMLOOP: begin
            mul_a = pr_ff;
            mul_b = y_v_ff[31:0];
         end
         S_PMSQ: begin
            mul_a = y_v_ff[31:0];
            mul_b = y_v_ff[31:0];
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      act_in   = act_ff;
      x_v_in   = x_v_ff;
      x_e_in   = x_e_ff;
      x_d_in   = x_d_ff;
      y_v_in   = y_v_ff;
      y_e_in   = y_e_ff;
      y_d_in   = y_d_ff;
      w_v_in   = w_v_ff;
      w_e_in   = w_e_ff;
      w_d_in   = w_d_ff;
      n_in     = n_ff;
      s_in     = s_ff;
      rem_in   = rem_ff;
      pr_in    = pr_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      sq_in    = sq_ff;
      sel_in   = sel_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (go) begin
               act_in   = action;
               x_v_in   = a_value;
               x_e_in   = a_scale;
               x_d_in   = 17'(a_known);
               y_v_in   = b_value;
               y_e_in   = b_scale;
               y_d_in   = 17'(b_known);
               state_in = S_DISP;
            end
         end

         S_DISP: begin
            sq_in = 1'b0;
            unique case (act_ff)
               tadic_pkg::ACT_CONVERT: begin
                  if (mod_mode) begin
                     w_v_in   = x_v_ff;
                     neg_in   = 1'b0;
                     rem_in   = 32'd0;
                     cnt_in   = FULL_KNOWN;
                     s_in     = x_e_ff;
                     ret_in   = S_CVLOOP;
                     state_in = S_RED;
                  end else begin
                     w_v_in   = x_v_ff;
                     w_e_in   = x_e_ff;
                     w_d_in   = FULL_D;
                     ret_in   = S_DONE;
                     state_in = S_NORM;
                  end
               end
               tadic_pkg::ACT_ADD, tadic_pkg::ACT_SUB: begin
                  if (mod_mode) begin
                     w_v_in   = (act_ff == tadic_pkg::ACT_SUB) ? (x_v_ff - y_v_ff)
                                                               : (x_v_ff + y_v_ff);
                     ret_in   = S_DONE;
                     state_in = S_NORM;
                  end else begin
                     state_in = S_ALIGN0;
                  end
               end
               tadic_pkg::ACT_MUL: begin
                  ret_in   = S_DONE;
                  state_in = S_MUL0;
               end
               tadic_pkg::ACT_DIV: begin
                  if (mod_mode) begin
                     w_v_in   = y_v_ff;
                     neg_in   = 1'b0;
                     rem_in   = 32'd0;
                     cnt_in   = FULL_KNOWN;
                     ret_in   = S_PMINIT;
                     state_in = S_RED;
                  end else begin
                     w_v_in   = x_v_ff;
                     n_in     = 64'd0;
                     cnt_in   = FULL_KNOWN;
                     state_in = S_DIVX;
                  end
               end
               tadic_pkg::ACT_POWER: begin
                  // x holds the running product, y the base
                  y_v_in   = x_v_ff;
                  y_e_in   = x_e_ff;
                  y_d_in   = x_d_ff;
                  n_in     = y_v_ff;
                  x_v_in   = mod_mode ? 64'(pr_one) : 64'd1;
                  x_e_in   = 16'd0;
                  x_d_in   = FULL_D;
                  state_in = S_PWLOOP;
               end
               default: begin
                  w_v_in   = 64'd0;
                  w_e_in   = 16'd0;
                  w_d_in   = 17'd0;
                  state_in = S_DONE;
               end
            endcase
         end

         // normalize w, then return
         S_NORM: begin
            if (mod_mode) begin
               neg_in   = w_v_ff[63];
               w_v_in   = w_v_ff[63] ? (64'd0 - w_v_ff) : w_v_ff;
               rem_in   = 32'd0;
               cnt_in   = FULL_KNOWN;
               w_e_in   = 16'd0;
               w_d_in   = FULL_D;
               state_in = S_RED;
            end else begin
               state_in = S_NSHIFT;
            end
         end

         S_NSHIFT: begin
            if ((w_v_ff != 64'd0) && !w_v_ff[0]) begin
               w_v_in = {1'b0, w_v_ff[63:1]};
               w_e_in = w_e_ff + 16'd1;
               w_d_in = (w_d_ff != 17'd0) ? (w_d_ff - 17'd1) : 17'd0;
            end else begin
               w_v_in   = w_v_ff & nmask;
               w_d_in   = 17'(dcap);
               state_in = ret_ff;
            end
         end

         // restoring remainder, one dividend bit per cycle
         S_RED: begin
            if (rem_sh >= {1'b0, prime}) begin
               rem_in = 32'(rem_sh - {1'b0, prime});
            end else begin
               rem_in = rem_sh[31:0];
            end
            w_v_in = {w_v_ff[62:0], 1'b0};
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               state_in = S_REDEND;
            end
         end

         S_REDEND: begin
            w_v_in   = (neg_ff && (rem_ff != 32'd0)) ? 64'(prime - rem_ff) : 64'(rem_ff);
            state_in = ret_ff;
         end

         // modular convert: walk the scale one step a cycle
         S_CVLOOP: begin
            if ($signed(s_ff) > 16'sd0) begin
               w_v_in = (dbl >= 64'(prime)) ? (dbl - 64'(prime)) : dbl;
               s_in   = s_ff - 16'd1;
            end else if ($signed(s_ff) < 16'sd0) begin
               w_v_in = {1'b0, hlf[63:1]};
               s_in   = s_ff + 16'd1;
            end else begin
               w_e_in   = 16'd0;
               w_d_in   = FULL_D;
               state_in = S_DONE;
            end
         end

         S_ALIGN0: begin
            if (x_v_ff == 64'd0) begin
               x_e_in = y_e_ff;
               x_d_in = y_d_ff;
            end else if (y_v_ff == 64'd0) begin
               y_e_in = x_e_ff;
               y_d_in = x_d_ff;
            end
            state_in = S_ALIGN1;
         end

         S_ALIGN1: begin
            cnt_in = (shift_dist >= FULL_D) ? FULL_KNOWN : shift_dist[6:0];
            if (!ediff[16] && (ediff != 17'd0)) begin
               sel_in = 1'b1;
               x_e_in = y_e_ff;
               x_d_in = x_d_ff + shift_dist;
            end else begin
               sel_in = 1'b0;
               y_e_in = x_e_ff;
               y_d_in = y_d_ff + shift_dist;
            end
            state_in = S_ASHIFT;
         end

         S_ASHIFT: begin
            if (cnt_ff != 7'd0) begin
               if (sel_ff) begin
                  x_v_in = {x_v_ff[62:0], 1'b0};
               end else begin
                  y_v_in = {y_v_ff[62:0], 1'b0};
               end
               cnt_in = cnt_ff - 7'd1;
            end else begin
               state_in = S_ADDSUB;
            end
         end

         S_ADDSUB: begin
            w_v_in   = (act_ff == tadic_pkg::ACT_SUB) ? (x_v_ff - y_v_ff) : (x_v_ff + y_v_ff);
            w_e_in   = x_e_ff;
            w_d_in   = min17(x_d_ff, y_d_ff);
            ret_in   = S_DONE;
            state_in = S_NORM;
         end

         // 64-bit low product from three partial products
         S_MUL0: begin
            state_in = S_MUL1;
         end

         S_MUL1: begin
            w_v_in   = prod;
            state_in = S_MUL2;
         end

         S_MUL2: begin
            w_v_in   = w_v_ff + {prod[31:0], 32'd0};
            state_in = S_MUL3;
         end

         S_MUL3: begin
            w_v_in   = w_v_ff + {prod[31:0], 32'd0};
            w_e_in   = xa_e + y_e_ff;
            w_d_in   = min17(xa_d, y_d_ff);
            state_in = S_NORM;
         end

         // exact division, one quotient bit per cycle
         S_DIVX: begin
            if (cnt_ff != 7'd0) begin
               if (w_v_ff[0]) begin
                  w_v_in = {1'b0, w_v_in_sub(w_v_ff, y_v_ff)};
               end else begin
                  w_v_in = {1'b0, w_v_ff[63:1]};
               end
               n_in   = {w_v_ff[0], n_ff[63:1]};
               cnt_in = cnt_ff - 7'd1;
            end else begin
               state_in = S_DIVEND;
            end
         end

         S_DIVEND: begin
            w_v_in   = n_ff;
            w_e_in   = x_e_ff - y_e_ff;
            w_d_in   = min17(x_d_ff, y_d_ff);
            ret_in   = S_DONE;
            state_in = S_NORM;
         end

         // power by square-and-multiply
         S_PWLOOP: begin
            if (n_ff == 64'd0) begin
               w_v_in   = x_v_ff;
               w_e_in   = x_e_ff;
               w_d_in   = x_d_ff;
               state_in = S_DONE;
            end else if (n_ff[0]) begin
               sq_in    = 1'b0;
               ret_in   = S_PWT;
               state_in = S_MUL0;
            end else begin
               state_in = S_PWSQ;
            end
         end

         S_PWT: begin
            x_v_in   = w_v_ff;
            x_e_in   = w_e_ff;
            x_d_in   = w_d_ff;
            state_in = S_PWSQ;
         end

         S_PWSQ: begin
            if (n_ff[63:1] == 63'd0) begin
               n_in     = 64'd0;
               state_in = S_PWLOOP;
            end else begin
               sq_in    = 1'b1;
               ret_in   = S_PWB;
               state_in = S_MUL0;
            end
         end

         S_PWB: begin
            y_v_in   = w_v_ff;
            y_e_in   = w_e_ff;
            y_d_in   = w_d_ff;
            n_in     = {1'b0, n_ff[63:1]};
            state_in = S_PWLOOP;
         end

         // modular inverse power: base in y, partial result in pr
         S_PMINIT: begin
            y_v_in   = w_v_ff;
            pr_in    = pr_one;
            n_in     = 64'(prime - offset);
            state_in = S_PMLOOP;
         end

         S_PMLOOP: begin
            if (n_ff == 64'd0) begin
               state_in = S_PMFIN;
            end else if (n_ff[0]) begin
               state_in = S_PMRX;
            end else begin
               state_in = S_PMSQ;
            end
         end

         S_PMRX: begin
            w_v_in   = prod;
            neg_in   = 1'b0;
            rem_in   = 32'd0;
            cnt_in   = FULL_KNOWN;
            ret_in   = S_PMRR;
            state_in = S_RED;
         end

         S_PMRR: begin
            pr_in    = w_v_ff[31:0];
            state_in = S_PMSQ;
         end

         S_PMSQ: begin
            if (n_ff[63:1] == 63'd0) begin
               n_in     = 64'd0;
               state_in = S_PMLOOP;
            end else begin
               state_in = S_PMSX;
            end
         end

         S_PMSX: begin
            w_v_in   = prod;
            neg_in   = 1'b0;
            rem_in   = 32'd0;
            cnt_in   = FULL_KNOWN;
            ret_in   = S_PMSR;
            state_in = S_RED;
         end

         S_PMSR: begin
            y_v_in   = w_v_ff;
            n_in     = {1'b0, n_ff[63:1]};
            state_in = S_PMLOOP;
         end

         S_PMFIN: begin
            y_v_in   = 64'(pr_ff);
            sq_in    = 1'b0;
            ret_in   = S_DONE;
            state_in = S_MUL0;
         end

         S_DONE: begin
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
      act_ff <= act_in;
      x_v_ff <= x_v_in;
      x_e_ff <= x_e_in;
      x_d_ff <= x_d_in;
      y_v_ff <= y_v_in;
      y_e_ff <= y_e_in;
      y_d_ff <= y_d_in;
      w_v_ff <= w_v_in;
      w_e_ff <= w_e_in;
      w_d_ff <= w_d_in;
      n_ff   <= n_in;
      s_ff   <= s_in;
      rem_ff <= rem_in;
      pr_ff  <= pr_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      sq_ff  <= sq_in;
      sel_ff <= sel_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign done.valid  = (state_ff == S_DONE);
   assign done.value  = w_v_ff;
   assign done.scale  = w_e_ff;
   assign done.known  = w_d_ff[6:0];

endmodule

`default_nettype wire

// ===== sv/two_adic_number_alu_top.sv =====
// Most actions end in a normalize (2-adic shift or modular remainder): mul and div
// run before it, modular div runs rounds of multiply and remainder, power runs rounds
// of multiply and normalize, and modular convert runs a remainder then a scale walk.
// One word at a time: busy stays high until the result, so no new word is taken
// before the last one is through.
// Throughput is set by the single restoring remainder loop and the shared 32x32 multiplier.
// Reset (synchronous, active high) idles the sequencer and clears both config registers.
`default_nettype none

module two_adic_number_alu_top (
   input  wire logic               clock,
   input  wire logic               reset,
   // request word
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [2:0]         req_action,
   input  wire logic [63:0]        req_a_value,
   input  wire logic signed [15:0] req_a_scale,
   input  wire logic [6:0]         req_a_known,
   input  wire logic [63:0]        req_b_value,
   input  wire logic signed [15:0] req_b_scale,
   input  wire logic [6:0]         req_b_known,
   // result word, one-cycle strobe, no backpressure
   output logic                    rsp_valid,
   output logic [63:0]             rsp_res_value,
   output logic signed [15:0]      rsp_res_scale,
   output logic [6:0]              rsp_res_known,
   // config write port
   input  wire logic               csr_write,
   input  wire logic [0:0]         csr_index,
   input  wire logic [31:0]        csr_wdata
);

   logic [31:0] prime_ff, offset_ff;
   logic        rsp_valid_ff;
   logic [63:0] rsp_value_ff;
   logic [15:0] rsp_scale_ff;
   logic [6:0]  rsp_known_ff;
   logic        go;
   logic        seq_busy;
   tadic_pkg::rsp_word_type done;

   // a word is taken only while the sequencer sits idle
   assign go   = start && !seq_busy;
   assign busy = seq_busy;

   // config registers: prime (0 = 2-adic mode) and inverse offset
   always_ff @(posedge clock) begin
      if (reset) begin
         prime_ff  <= 32'd0;
         offset_ff <= 32'd0;
      end else if (csr_write) begin
         unique case (csr_index)
            tadic_pkg::CSR_PRIME:  prime_ff  <= csr_wdata;
            tadic_pkg::CSR_OFFSET: offset_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   tadic_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .go      (go),
      .action  (req_action),
      .a_value (req_a_value),
      .a_scale (req_a_scale),
      .a_known (req_a_known),
      .b_value (req_b_value),
      .b_scale (req_b_scale),
      .b_known (req_b_known),
      .prime   (prime_ff),
      .offset  (offset_ff),
      .busy    (seq_busy),
      .done    (done)
   );

   // output register: result shown for exactly one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= done.valid;
      end
      if (done.valid) begin
         rsp_value_ff <= done.value;
         rsp_scale_ff <= done.scale;
         rsp_known_ff <= done.known;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_res_value = rsp_value_ff;
   assign rsp_res_scale = rsp_scale_ff;
   assign rsp_res_known = rsp_known_ff;

endmodule

`default_nettype wire
